// ----- src/rtd_pkg.sv -----
// package: shared constants, operation codes and controller state type
`timescale 1ns / 1ps

package rtd_pkg;

   localparam int RTD_POOL_COUNT    = 64;
   localparam int RTD_HISTORY_DEPTH = 16;
   localparam int RTD_CLASS_COUNT   = 256;

   localparam int RTD_MIN_COUNT_FOR_THRASH = 4;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_CHECK  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      STATE_INIT,
      STATE_IDLE,
      STATE_META,
      STATE_H_RD,
      STATE_N_RD_D,
      STATE_N_UPD_D,
      STATE_N_RD_R,
      STATE_N_UPD_R,
      STATE_Z_RD,
      STATE_Z_D,
      STATE_Z_R,
      STATE_DONE
   } state_type;

endpackage

// ----- src/rtd_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps

module rtd_ram import rtd_pkg::*; #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- src/rebalance_thrash_detector.sv -----
// top level: per-pool slab move history and thrash check controller
//
//  channel   | ports                                            | flow
//  ----------+--------------------------------------------------+---------------------------
//  request   | start, busy, req_operation, req_pool_id,         | taken when start & !busy
//            | req_donor_class, req_receiver_class              |
//  response  | rsp_strobe, rsp_thrashing, rsp_history_count     | one cycle, rsp_strobe high
//
// record, clear, ignored requests and checks of an empty history keep busy high only
// in the meta state; the response follows the cycle after. a check over held moves
// runs a net-change pass, per move a history read, then a read-modify-write of donor
// and receiver counters in the class counter ram, and then a second pass over the
// history to zero them again.
// after reset the class counter ram is swept to zero with busy high.
// the response is never held off; a new request may be taken while it is shown.
`timescale 1ns / 1ps

module rebalance_thrash_detector import rtd_pkg::*; #(
   parameter int POOL_COUNT    = RTD_POOL_COUNT,
   parameter int HISTORY_DEPTH = RTD_HISTORY_DEPTH,
   parameter int CLASS_COUNT   = RTD_CLASS_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_operation,
   input  logic [5:0] req_pool_id,
   input  logic [7:0] req_donor_class,
   input  logic [7:0] req_receiver_class,
   output logic       rsp_strobe,
   output logic       rsp_thrashing,
   output logic [4:0] rsp_history_count
);

   // widths
   localparam int PW     = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
   localparam int SW     = $clog2(HISTORY_DEPTH);
   localparam int CW     = $clog2(HISTORY_DEPTH + 1);
   localparam int MW     = SW + CW;
   localparam int HDEPTH = POOL_COUNT * HISTORY_DEPTH;
   localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
   localparam int NDEPTH = CLASS_COUNT + 1;
   localparam int NW     = $clog2(NDEPTH);
   localparam int NVW    = CW + 1;
   localparam int AW     = $clog2(2 * HISTORY_DEPTH + 1);

   // slot arithmetic, both operands below the depth
   function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = (CW + 1)'(a) + (CW + 1)'(b);
      if (s >= (CW + 1)'(HISTORY_DEPTH)) begin
         s = s - (CW + 1)'(HISTORY_DEPTH);
      end
      return SW'(s);
   endfunction

   // ids beyond the class range share one extra counter
   function automatic logic [NW-1:0] class_bucket(input logic [7:0] id);
      logic [NW-1:0] b;
      if (int'(id) < CLASS_COUNT) begin
         b = NW'(id);
      end else begin
         b = NW'(CLASS_COUNT);
      end
      return b;
   endfunction

   // controller registers
   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [5:0]         pool_ff, pool_in;
   logic               pool_ok_ff, pool_ok_in;
   logic [7:0]         donor_ff, donor_in;
   logic [7:0]         recv_ff, recv_in;
   logic [HAW-1:0]     base_ff, base_in;
   logic [SW-1:0]      oldest_ff, oldest_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      abs_ff, abs_in;
   logic [NW-1:0]      ent_d_ff, ent_d_in;
   logic [NW-1:0]      ent_r_ff, ent_r_in;
   logic [NW-1:0]      init_ff, init_in;
   logic [POOL_COUNT-1:0] pool_valid_ff, pool_valid_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_thrash_ff, rsp_thrash_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;

   // ram ports
   logic               meta_wr_en, meta_rd_en;
   logic [PW-1:0]      meta_wr_addr, meta_rd_addr;
   logic [MW-1:0]      meta_wr_data, meta_rd_data;
   logic               hist_wr_en, hist_rd_en;
   logic [HAW-1:0]     hist_wr_addr, hist_rd_addr;
   logic [15:0]        hist_wr_data, hist_rd_data;
   logic               net_wr_en, net_rd_en;
   logic [NW-1:0]      net_wr_addr, net_rd_addr;
   logic [NVW-1:0]     net_wr_data, net_rd_data;

   // pool meta view, an unwritten or cleared pool reads as empty
   logic [PW-1:0]      pidx;
   logic               cur_valid;
   logic [SW-1:0]      cur_oldest;
   logic [CW-1:0]      cur_count;
   logic [HAW-1:0]     cur_base;
   logic               last_move;
   logic [AW-1:0]      even_abs;

   assign pidx       = PW'(pool_ff);
   assign cur_valid  = pool_valid_ff[pidx];
   assign cur_oldest = cur_valid ? meta_rd_data[MW-1:CW] : '0;
   assign cur_count  = cur_valid ? meta_rd_data[CW-1:0] : '0;
   assign cur_base   = HAW'(pidx) * HAW'(HISTORY_DEPTH);
   assign last_move  = (idx_ff == (count_ff - CW'(1)));
   assign even_abs   = {abs_ff[AW-1:1], 1'b0};

   // pool meta: oldest slot and held count
   rtd_ram #(.WIDTH(MW), .DEPTH(POOL_COUNT)) u_meta_ram (
      .clock      (clock),
      .wr_en      (meta_wr_en),
      .wr_addr    (meta_wr_addr),
      .wr_data    (meta_wr_data),
      .rd_en      (meta_rd_en),
      .rd_addr    (meta_rd_addr),
      .rd_data_ff (meta_rd_data)
   );

   // move history: donor in the upper byte, receiver in the lower
   rtd_ram #(.WIDTH(16), .DEPTH(HDEPTH)) u_hist_ram (
      .clock      (clock),
      .wr_en      (hist_wr_en),
      .wr_addr    (hist_wr_addr),
      .wr_data    (hist_wr_data),
      .rd_en      (hist_rd_en),
      .rd_addr    (hist_rd_addr),
      .rd_data_ff (hist_rd_data)
   );

   // per-class net slab change, kept at zero between checks
   rtd_ram #(.WIDTH(NVW), .DEPTH(NDEPTH)) u_net_ram (
      .clock      (clock),
      .wr_en      (net_wr_en),
      .wr_addr    (net_wr_addr),
      .wr_data    (net_wr_data),
      .rd_en      (net_rd_en),
      .rd_addr    (net_rd_addr),
      .rd_data_ff (net_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_INIT;
         init_ff       <= '0;
         pool_valid_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         pool_valid_ff <= pool_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff         <= op_in;
      pool_ff       <= pool_in;
      pool_ok_ff    <= pool_ok_in;
      donor_ff      <= donor_in;
      recv_ff       <= recv_in;
      base_ff       <= base_in;
      oldest_ff     <= oldest_in;
      count_ff      <= count_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      abs_ff        <= abs_in;
      ent_d_ff      <= ent_d_in;
      ent_r_ff      <= ent_r_in;
      rsp_thrash_ff <= rsp_thrash_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pool_in       = pool_ff;
      pool_ok_in    = pool_ok_ff;
      donor_in      = donor_ff;
      recv_in       = recv_ff;
      base_in       = base_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      abs_in        = abs_ff;
      ent_d_in      = ent_d_ff;
      ent_r_in      = ent_r_ff;
      init_in       = init_ff;
      pool_valid_in = pool_valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_thrash_in = rsp_thrash_ff;
      rsp_count_in  = rsp_count_ff;

      meta_wr_en   = 1'b0;
      meta_wr_addr = pidx;
      meta_wr_data = '0;
      meta_rd_en   = 1'b0;
      meta_rd_addr = PW'(req_pool_id);
      hist_wr_en   = 1'b0;
      hist_wr_addr = cur_base + HAW'(cur_oldest);
      hist_wr_data = {donor_ff, recv_ff};
      hist_rd_en   = 1'b0;
      hist_rd_addr = base_ff + HAW'(slot_ff);
      net_wr_en    = 1'b0;
      net_wr_addr  = ent_d_ff;
      net_wr_data  = '0;
      net_rd_en    = 1'b0;
      net_rd_addr  = ent_d_ff;

      unique case (state_ff)
         // zero the class counters once after reset
         STATE_INIT: begin
            net_wr_en   = 1'b1;
            net_wr_addr = init_ff;
            init_in     = init_ff + NW'(1);
            if (init_ff == NW'(NDEPTH - 1)) begin
               state_in = STATE_IDLE;
            end
         end

         STATE_IDLE: begin
            if (start) begin
               op_in      = op_type'(req_operation);
               pool_in    = req_pool_id;
               pool_ok_in = (int'(req_pool_id) < POOL_COUNT);
               donor_in   = req_donor_class;
               recv_in    = req_receiver_class;
               meta_rd_en = 1'b1;
               state_in   = STATE_META;
            end
         end

         // pool meta is back, decide what the request does
         STATE_META: begin
            base_in       = cur_base;
            rsp_thrash_in = 1'b0;
            if (!pool_ok_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_count_in  = '0;
               state_in      = STATE_IDLE;
            end else begin
               unique case (op_ff)
                  OP_RECORD: begin
                     hist_wr_en    = 1'b1;
                     meta_wr_en    = 1'b1;
                     pool_valid_in[pidx] = 1'b1;
                     if (cur_count == CW'(HISTORY_DEPTH)) begin
                        // full: overwrite the oldest and move on
                        hist_wr_addr = cur_base + HAW'(cur_oldest);
                        meta_wr_data = {slot_add(cur_oldest, CW'(1)), cur_count};
                        rsp_count_in = 5'(cur_count);
                     end else begin
                        hist_wr_addr = cur_base + HAW'(slot_add(cur_oldest, cur_count));
                        meta_wr_data = {cur_oldest, cur_count + CW'(1)};
                        rsp_count_in = 5'(cur_count + CW'(1));
                     end
                     rsp_strobe_in = 1'b1;
                     state_in      = STATE_IDLE;
                  end
                  OP_CHECK: begin
                     oldest_in    = cur_oldest;
                     count_in     = cur_count;
                     slot_in      = cur_oldest;
                     idx_in       = '0;
                     abs_in       = '0;
                     rsp_count_in = 5'(cur_count);
                     if (cur_count == '0) begin
                        rsp_strobe_in = 1'b1;
                        state_in      = STATE_IDLE;
                     end else begin
                        state_in = STATE_H_RD;
                     end
                  end
                  OP_CLEAR: begin
                     pool_valid_in[pidx] = 1'b0;
                     rsp_count_in        = '0;
                     rsp_strobe_in       = 1'b1;
                     state_in            = STATE_IDLE;
                  end
                  default: begin
                     // unknown operation: report the count only
                     rsp_count_in  = 5'(cur_count);
                     rsp_strobe_in = 1'b1;
                     state_in      = STATE_IDLE;
                  end
               endcase
            end
         end

         // net-change pass over the history
         STATE_H_RD: begin
            hist_rd_en = 1'b1;
            state_in   = STATE_N_RD_D;
         end

         STATE_N_RD_D: begin
            ent_d_in    = class_bucket(hist_rd_data[15:8]);
            ent_r_in    = class_bucket(hist_rd_data[7:0]);
            net_rd_en   = 1'b1;
            net_rd_addr = class_bucket(hist_rd_data[15:8]);
            state_in    = STATE_N_UPD_D;
         end

         // donor loses a slab: |net| grows unless it was positive
         STATE_N_UPD_D: begin
            net_wr_en   = 1'b1;
            net_wr_addr = ent_d_ff;
            net_wr_data = net_rd_data - NVW'(1);
            if (net_rd_data[NVW-1] || (net_rd_data == '0)) begin
               abs_in = abs_ff + AW'(1);
            end else begin
               abs_in = abs_ff - AW'(1);
            end
            state_in = STATE_N_RD_R;
         end

         // read after the donor write so a shared class sees it
         STATE_N_RD_R: begin
            net_rd_en   = 1'b1;
            net_rd_addr = ent_r_ff;
            state_in    = STATE_N_UPD_R;
         end

         // receiver gains a slab: |net| grows unless it was negative
         STATE_N_UPD_R: begin
            net_wr_en   = 1'b1;
            net_wr_addr = ent_r_ff;
            net_wr_data = net_rd_data + NVW'(1);
            if (!net_rd_data[NVW-1]) begin
               abs_in = abs_ff + AW'(1);
            end else begin
               abs_in = abs_ff - AW'(1);
            end
            if (last_move) begin
               slot_in  = oldest_ff;
               idx_in   = '0;
               state_in = STATE_Z_RD;
            end else begin
               slot_in  = slot_add(slot_ff, CW'(1));
               idx_in   = idx_ff + CW'(1);
               state_in = STATE_H_RD;
            end
         end

         // second pass puts touched counters back to zero
         STATE_Z_RD: begin
            hist_rd_en = 1'b1;
            state_in   = STATE_Z_D;
         end

         STATE_Z_D: begin
            net_wr_en   = 1'b1;
            net_wr_addr = class_bucket(hist_rd_data[15:8]);
            ent_r_in    = class_bucket(hist_rd_data[7:0]);
            state_in    = STATE_Z_R;
         end

         STATE_Z_R: begin
            net_wr_en   = 1'b1;
            net_wr_addr = ent_r_ff;
            if (last_move) begin
               state_in = STATE_DONE;
            end else begin
               slot_in  = slot_add(slot_ff, CW'(1));
               idx_in   = idx_ff + CW'(1);
               state_in = STATE_Z_RD;
            end
         end

         // thrashing when twice the halved sum is within the count and the count exceeds RTD_MIN_COUNT_FOR_THRASH
         STATE_DONE: begin
            rsp_thrash_in = (even_abs <= AW'(count_ff)) &&
                            (count_ff > CW'(RTD_MIN_COUNT_FOR_THRASH));
            rsp_count_in  = 5'(count_ff);
            rsp_strobe_in = 1'b1;
            state_in      = STATE_IDLE;
         end

         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != STATE_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_thrashing     = rsp_thrash_ff;
   assign rsp_history_count = rsp_count_ff;

endmodule
